### src/assert_macros.svh
// assertion helpers for the rtl files, included by the table controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// when the trigger holds, the consequence must hold in the following cycle
`define ASSERT_NEXT(lbl, clk, rst, trig, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

### src/hksl_pkg.sv
package hksl_pkg;

   localparam int ENTRIES     = 64;
   localparam int VALUE_WIDTH = 32;
   localparam int HASH_W      = 32;
   localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W       = $clog2(ENTRIES + 1);

   localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FULL      = 3'd2,
      ST_FOUND     = 3'd3,
      ST_NOT_FOUND = 3'd4,
      ST_CLEARED   = 3'd5
   } status_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  key_byte;
      logic        last_byte;
      logic [31:0] entry_value;
   } req_payload_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] found_value;
      logic [31:0] key_hash;
   } rsp_payload_type;

   // one table entry as stored in the memory
   typedef struct packed {
      logic [HASH_W-1:0]      hash;
      logic [VALUE_WIDTH-1:0] value;
   } entry_type;

   // completed key handed to the table controller
   typedef struct packed {
      logic                   start;
      op_type                 op;
      logic [HASH_W-1:0]      hash;
      logic [VALUE_WIDTH-1:0] value;
   } ctrl_cmd_type;

   // result offered by the table controller
   typedef struct packed {
      logic        valid;
      status_type  status;
      logic [31:0] found_value;
      logic [31:0] key_hash;
   } ctrl_res_type;

endpackage

### src/hksl_ram.sv
module hksl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/hksl_hash.sv
module hksl_hash
   import hksl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  op_type            op,
   input  logic [7:0]        key_byte,
   input  logic              last_byte,
   output logic [HASH_W-1:0] hash_out
);

   logic [HASH_W-1:0] running_ff;
   logic [HASH_W-1:0] running_in;

   // hash * 33 + byte, wrapping
   assign hash_out = (running_ff << 5) + running_ff + HASH_W'(key_byte);

   always_comb begin
      running_in = running_ff;
      if (accept) begin
         case (op)
            OP_INSERT, OP_LOOKUP: running_in = last_byte ? HASH_SEED : hash_out;
            OP_CLEAR:             running_in = HASH_SEED;
            default:              running_in = running_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= HASH_SEED;
      end else begin
         running_ff <= running_in;
      end
   end

endmodule

### src/hksl_ctrl.sv
module hksl_ctrl
   import hksl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  ctrl_cmd_type cmd,
   input  logic         res_ack,
   output ctrl_res_type res,
   output logic         busy
);

`include "assert_macros.svh"

   typedef enum logic [2:0] {
      S_IDLE,
      S_PROBE,
      S_CMP,
      S_SHIFT,
      S_SHIFT_LAST,
      S_INS,
      S_DONE
   } state_type;

   state_type              state_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       lo_ff;
   logic [CNT_W-1:0]       hi_ff;
   logic [IDX_W-1:0]       mid_ff;
   logic [IDX_W-1:0]       src_ff;
   logic [IDX_W-1:0]       wr_addr_ff;
   logic                   pend_ff;
   logic                   hit_ff;
   logic                   lookup_ff;
   logic [VALUE_WIDTH-1:0] hit_val_ff;
   logic [HASH_W-1:0]      hash_ff;
   logic [VALUE_WIDTH-1:0] value_ff;
   status_type             status_ff;

   logic [CNT_W-1:0]       mid_in;
   logic                   ram_we;
   logic [IDX_W-1:0]       ram_waddr;
   entry_type              ram_wdata;
   logic                   ram_re;
   logic [IDX_W-1:0]       ram_raddr;
   entry_type              ram_rdata;
   logic [63:0]            hit_val_wide;

   assign mid_in = lo_ff + ((hi_ff - lo_ff) >> 1);

   always_comb begin
      ram_re    = 1'b0;
      ram_raddr = mid_in[IDX_W-1:0];
      ram_we    = 1'b0;
      ram_waddr = wr_addr_ff;
      ram_wdata = ram_rdata;
      unique case (state_ff)
         S_PROBE: begin
            ram_re = (lo_ff < hi_ff);
         end
         S_SHIFT: begin
            ram_re    = 1'b1;
            ram_raddr = src_ff;
            ram_we    = pend_ff;
         end
         S_SHIFT_LAST: begin
            ram_we = 1'b1;
         end
         S_INS: begin
            ram_we    = 1'b1;
            ram_waddr = lo_ff[IDX_W-1:0];
            ram_wdata = '{hash: hash_ff, value: value_ff};
         end
         default: begin
            ram_re = 1'b0;
         end
      endcase
   end

   hksl_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (cmd.start) begin
                  hash_ff   <= cmd.hash;
                  value_ff  <= cmd.value;
                  lookup_ff <= (cmd.op == OP_LOOKUP);
                  hit_ff    <= 1'b0;
                  lo_ff     <= '0;
                  hi_ff     <= count_ff;
                  if (cmd.op == OP_CLEAR) begin
                     count_ff  <= '0;
                     hash_ff   <= '0;
                     status_ff <= ST_CLEARED;
                     state_ff  <= S_DONE;
                  end else begin
                     state_ff <= S_PROBE;
                  end
               end
            end
            S_PROBE: begin
               mid_ff <= mid_in[IDX_W-1:0];
               if (lo_ff < hi_ff) begin
                  state_ff <= S_CMP;
               end else if (lookup_ff) begin
                  status_ff <= hit_ff ? ST_FOUND : ST_NOT_FOUND;
                  state_ff  <= S_DONE;
               end else if (hit_ff) begin
                  status_ff <= ST_DUPLICATE;
                  state_ff  <= S_DONE;
               end else if (count_ff == CNT_W'(ENTRIES)) begin
                  status_ff <= ST_FULL;
                  state_ff  <= S_DONE;
               end else if (count_ff > lo_ff) begin
                  src_ff   <= IDX_W'(count_ff - CNT_W'(1));
                  pend_ff  <= 1'b0;
                  state_ff <= S_SHIFT;
               end else begin
                  state_ff <= S_INS;
               end
            end
            S_CMP: begin
               if (ram_rdata.hash < hash_ff) begin
                  lo_ff <= CNT_W'(mid_ff) + CNT_W'(1);
               end else begin
                  hi_ff <= CNT_W'(mid_ff);
               end
               // sorted and unique, so an exact hit ends at the lower bound
               if (ram_rdata.hash == hash_ff) begin
                  hit_ff     <= 1'b1;
                  hit_val_ff <= ram_rdata.value;
               end
               state_ff <= S_PROBE;
            end
            S_SHIFT: begin
               pend_ff    <= 1'b1;
               wr_addr_ff <= src_ff + IDX_W'(1);
               if (src_ff == lo_ff[IDX_W-1:0]) begin
                  state_ff <= S_SHIFT_LAST;
               end else begin
                  src_ff <= src_ff - IDX_W'(1);
               end
            end
            S_SHIFT_LAST: begin
               pend_ff  <= 1'b0;
               state_ff <= S_INS;
            end
            S_INS: begin
               count_ff  <= count_ff + CNT_W'(1);
               status_ff <= ST_INSERTED;
               state_ff  <= S_DONE;
            end
            S_DONE: begin
               if (res_ack) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign hit_val_wide     = 64'(hit_val_ff);
   assign res.valid        = (state_ff == S_DONE);
   assign res.status       = status_ff;
   assign res.found_value  = (status_ff == ST_FOUND) ? hit_val_wide[31:0] : 32'd0;
   assign res.key_hash     = hash_ff;
   assign busy             = (state_ff != S_IDLE);

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(ENTRIES),
      "entry count beyond table depth")
   `ASSERT_ALWAYS(a_start_idle, clock, reset, !cmd.start || state_ff == S_IDLE,
      "key started while controller busy")
   `ASSERT_ALWAYS(a_write_in_range, clock, reset, !ram_we || CNT_W'(ram_waddr) <= count_ff,
      "table write outside the filled range")
   `ASSERT_NEXT(a_result_holds, clock, reset, state_ff == S_DONE && !res_ack,
      state_ff == S_DONE && $stable(status_ff) && $stable(hash_ff),
      "pending result changed before it was taken")

endmodule

### src/hashed_key_sorted_lookup_core.sv
// channel   | ports                                  | payload
// ----------+----------------------------------------+---------------------------------
// request   | req_valid, req_stall, req_payload      | op, key_byte, last_byte, value
// response  | rsp_valid, rsp_stall, rsp_payload      | status, found_value, key_hash
//
// key bytes that are not last only advance the running hash; unused op codes are ignored
// a completed lookup runs a binary search through the single-read-port table memory
// (read, then compare); an insert then shifts the entries above its position up one
// slot and writes the key, or only writes it when the key lands at the end
// a clear resets the entry count; reset is synchronous and needs no clearing pass
// req_stall is high while a key is being searched or its result waits for the output slot
// one finished transaction can sit in the output register while the next bytes hash
module hashed_key_sorted_lookup_core
   import hksl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic              req_fire;
   logic [HASH_W-1:0] key_hash;
   logic [63:0]       value_wide;
   ctrl_cmd_type      cmd;
   ctrl_res_type      res;
   logic              ctrl_busy;
   logic              rsp_load;

   logic              rsp_valid_ff;
   rsp_payload_type   rsp_payload_ff;

   // controller busy is registered, so stall never waits on valid
   assign req_stall = ctrl_busy;
   assign req_fire  = req_valid && !req_stall;

   // running djb2 hash, one byte per accepted transaction
   hksl_hash u_hash (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_fire),
      .op        (req_payload.op),
      .key_byte  (req_payload.key_byte),
      .last_byte (req_payload.last_byte),
      .hash_out  (key_hash)
   );

   // stored values are cut to the table's value width
   assign value_wide = 64'(req_payload.entry_value);

   always_comb begin
      cmd.op    = req_payload.op;
      cmd.hash  = key_hash;
      cmd.value = value_wide[VALUE_WIDTH-1:0];
      case (req_payload.op)
         OP_INSERT, OP_LOOKUP: cmd.start = req_fire && req_payload.last_byte;
         OP_CLEAR:             cmd.start = req_fire;
         default:              cmd.start = 1'b0;
      endcase
   end

   // sorted table: binary search, shift-insert and clear
   hksl_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .res_ack (rsp_load),
      .res     (res),
      .busy    (ctrl_busy)
   );

   // output register, refilled when empty or being drained this cycle
   assign rsp_load = res.valid && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_payload_ff.status      <= res.status;
         rsp_payload_ff.found_value <= res.found_value;
         rsp_payload_ff.key_hash    <= res.key_hash;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
